// ===== rtl/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg: shared types and constants of the region quantile selector
// Field widths, configuration register indexes and the control bundle that
// the sequencer hands to each channel unit.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int PIX_W      = 8;
    localparam int BINS       = 256;
    localparam int Q_W        = 16;
    localparam int QCNT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Q_REGS     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_QCOUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QB     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QD     = 3'd4;

    localparam logic [QCNT_W-1:0] QCOUNT_RESET = 3'd1;
    localparam logic [Q_W-1:0]    Q_RESET      = 16'd32768;

    typedef struct packed {
        logic             pix_acc;     // pixel request accepted this cycle
        logic             pix_cnt;     // accepted pixel is counted
        logic             walk_start;  // reset cumulative sums and selections
        logic             walk_rd;     // read a bin for the walk and zero it
        logic             clear_wr;    // zero a bin during the reset sweep
        logic [PIX_W-1:0] sweep_addr;  // bin addressed by walk or sweep
    } t_chan_ctrl;

endpackage

// ===== rtl/rqs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rqs_cfg_if: configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rqs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rqs_pkg::CFG_IDX_W-1:0]    index;
    logic [rqs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rqs_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rqs_pixel_if: pixel channel
// One RGB pixel of a region per request, with a flag on the final pixel.
// ----------------------------------------------------------------------------
interface rqs_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [rqs_pkg::PIX_W-1:0]    pixel_red;
    logic [rqs_pkg::PIX_W-1:0]    pixel_green;
    logic [rqs_pkg::PIX_W-1:0]    pixel_blue;
    logic                         last_pixel;

    modport source (output valid, output pixel_red, output pixel_green,
                    output pixel_blue, output last_pixel, input ready);
    modport sink   (input valid, input pixel_red, input pixel_green,
                    input pixel_blue, input last_pixel, output ready);
endinterface

// ===== rtl/rqs_result_if.sv =====
// ----------------------------------------------------------------------------
// rqs_result_if: result channel
// One quantile color per request, with overflow and final-color flags.
// ----------------------------------------------------------------------------
interface rqs_result_if;
    logic                         valid;
    logic                         ready;
    logic [rqs_pkg::PIX_W-1:0]    out_red;
    logic [rqs_pkg::PIX_W-1:0]    out_green;
    logic [rqs_pkg::PIX_W-1:0]    out_blue;
    logic                         region_overflow;
    logic                         last_result;

    modport source (output valid, output out_red, output out_green,
                    output out_blue, output region_overflow,
                    output last_result, input ready);
    modport sink   (input valid, input out_red, input out_green,
                    input out_blue, input region_overflow,
                    input last_result, output ready);
endinterface

// ===== rtl/rqs_hist_ram.sv =====
// ----------------------------------------------------------------------------
// rqs_hist_ram: histogram bin memory
// 256 bins, one registered read port and one write port. A read and a write
// of the same bin in one cycle return the old contents.
// ----------------------------------------------------------------------------
module rqs_hist_ram #(
    parameter int DATA_W = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [rqs_pkg::PIX_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0]         o_rd_data,
    input  logic                      i_wr_en,
    input  logic [rqs_pkg::PIX_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]         i_wr_data
);

    logic [DATA_W-1:0] mem [rqs_pkg::BINS];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rqs_chan_unit.sv =====
// ----------------------------------------------------------------------------
// rqs_chan_unit: histogram and quantile search for one color channel
// Counts pixels into the bin memory by read-modify-write with forwarding,
// then walks the bins once, zeroing each, and picks the value for every slot.
// ----------------------------------------------------------------------------
module rqs_chan_unit #(
    parameter int CNT_W = 17,
    parameter int SLOTS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rqs_pkg::t_chan_ctrl       i_ctrl,
    input  logic [rqs_pkg::PIX_W-1:0] i_pix,
    input  logic [CNT_W-1:0]          i_idx [SLOTS],
    output logic [rqs_pkg::PIX_W-1:0] o_sel [SLOTS]
);

    logic                      w_rd_en;
    logic [rqs_pkg::PIX_W-1:0] w_rd_addr;
    logic [CNT_W-1:0]          w_rd_data;
    logic                      w_wr_en;
    logic [rqs_pkg::PIX_W-1:0] w_wr_addr;
    logic [CNT_W-1:0]          w_wr_data;

    logic                      r_s1_vld;
    logic [rqs_pkg::PIX_W-1:0] r_s1_addr;
    logic                      r_fw_vld;
    logic [rqs_pkg::PIX_W-1:0] r_fw_addr;
    logic [CNT_W-1:0]          r_fw_data;
    logic [CNT_W-1:0]          w_base;
    logic [CNT_W-1:0]          w_inc;

    logic                      r_wk_vld;
    logic [rqs_pkg::PIX_W-1:0] r_wk_addr;
    logic [CNT_W-1:0]          r_cum;
    logic [CNT_W-1:0]          w_cum_next;
    logic [SLOTS-1:0]          r_found;
    logic [rqs_pkg::PIX_W-1:0] r_sel [SLOTS];

    assign w_rd_en   = i_ctrl.pix_acc | i_ctrl.walk_rd;
    assign w_rd_addr = i_ctrl.pix_acc ? i_pix : i_ctrl.sweep_addr;

    // The bin written in the previous cycle reads stale; take the forwarded count.
    assign w_base = (r_fw_vld && (r_fw_addr == r_s1_addr)) ? r_fw_data : w_rd_data;
    assign w_inc  = w_base + CNT_W'(1);

    assign w_wr_en   = r_s1_vld | i_ctrl.walk_rd | i_ctrl.clear_wr;
    assign w_wr_addr = r_s1_vld ? r_s1_addr : i_ctrl.sweep_addr;
    assign w_wr_data = r_s1_vld ? w_inc : '0;

    rqs_hist_ram #(
        .DATA_W (CNT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_wk_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctrl.pix_acc & i_ctrl.pix_cnt;
            r_fw_vld <= r_s1_vld;
            r_wk_vld <= i_ctrl.walk_rd;
        end
        r_s1_addr <= i_pix;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= w_inc;
        r_wk_addr <= i_ctrl.sweep_addr;
    end

    assign w_cum_next = r_cum + w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
            r_cum   <= '0;
        end else if (i_ctrl.walk_start) begin
            r_found <= '0;
            r_cum   <= '0;
        end else if (r_wk_vld) begin
            r_cum <= w_cum_next;
            for (int k = 0; k < SLOTS; k++) begin
                if (!r_found[k] && (w_cum_next > i_idx[k])) begin
                    r_found[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOTS; k++) begin
            if (i_ctrl.walk_start) begin
                r_sel[k] <= '1;
            end else if (r_wk_vld && !r_found[k] && (w_cum_next > i_idx[k])) begin
                r_sel[k] <= r_wk_addr;
            end
        end
    end

    assign o_sel = r_sel;

endmodule

// ===== rtl/rgb_region_quantile_select.sv =====
// ----------------------------------------------------------------------------
// rgb_region_quantile_select: per-region color quantiles by histogram
// Sequence: a pixel is taken every cycle while the intake is open; after the last
//   pixel the quantile indexes are registered, the bins are walked and zeroed, a
//   settle step sums the last bin, and colors follow one per cycle while the sink
//   is ready. The pixel intake stays closed until the final color is taken.
// Throughput: one pixel per cycle while idle, bound by the bin read-modify-write.
// Reset: a sweep over all 256 bins zeroes the bin memories; no pixel is taken then.
// ----------------------------------------------------------------------------
module rgb_region_quantile_select #(
    parameter int MAX_PIXELS     = 65536,
    parameter int QUANTILE_SLOTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rqs_cfg_if.sink          i_cfg,
    rqs_pixel_if.sink        i_pixel,
    rqs_result_if.source     o_result
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int KW    = (QUANTILE_SLOTS > 1) ? $clog2(QUANTILE_SLOTS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);
    localparam logic [rqs_pkg::QCNT_W-1:0] SLOT_MAX = rqs_pkg::QCNT_W'(QUANTILE_SLOTS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [rqs_pkg::PIX_W-1:0]    r_addr;
    logic                         r_settle;
    logic [CNT_W-1:0]             r_total;
    logic                         r_dropped;
    logic [rqs_pkg::QCNT_W-1:0]   r_qcount;
    logic [rqs_pkg::Q_W-1:0]      r_q [rqs_pkg::Q_REGS];
    logic [CNT_W-1:0]             r_idx [QUANTILE_SLOTS];
    logic [KW-1:0]                r_k;
    logic [KW-1:0]                r_last_k;
    logic [rqs_pkg::QCNT_W-1:0]   w_last_k;

    logic                         w_pix_acc;
    logic                         w_res_acc;
    logic                         w_cfg_acc;
    logic                         w_counted;
    rqs_pkg::t_chan_ctrl          w_ctrl;

    logic [rqs_pkg::PIX_W-1:0]    w_sel_r [QUANTILE_SLOTS];
    logic [rqs_pkg::PIX_W-1:0]    w_sel_g [QUANTILE_SLOTS];
    logic [rqs_pkg::PIX_W-1:0]    w_sel_b [QUANTILE_SLOTS];

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcount <= rqs_pkg::QCOUNT_RESET;
            for (int i = 0; i < rqs_pkg::Q_REGS; i++) begin
                r_q[i] <= rqs_pkg::Q_RESET;
            end
        end else if (w_cfg_acc) begin
            case (i_cfg.index)
                rqs_pkg::CFG_QCOUNT: r_qcount <= i_cfg.data[rqs_pkg::QCNT_W-1:0];
                rqs_pkg::CFG_QA:     r_q[0]   <= i_cfg.data;
                rqs_pkg::CFG_QB:     r_q[1]   <= i_cfg.data;
                rqs_pkg::CFG_QC:     r_q[2]   <= i_cfg.data;
                rqs_pkg::CFG_QD:     r_q[3]   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign i_pixel.ready  = (r_state == ST_IDLE);
    assign w_pix_acc      = i_pixel.valid & i_pixel.ready;
    assign o_result.valid = (r_state == ST_EMIT);
    assign w_res_acc      = o_result.valid & o_result.ready;
    assign w_counted      = (r_total < MAX_CNT);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_addr == '1) n_state = ST_IDLE;
            ST_IDLE:  if (w_pix_acc && i_pixel.last_pixel) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_WALK;
            ST_WALK:  if (r_settle) n_state = ST_EMIT;
            ST_EMIT:  if (w_res_acc && (r_k == r_last_k)) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Color count clamped to one through the number of slots.
    always_comb begin
        if (r_qcount == '0) begin
            w_last_k = '0;
        end else if (r_qcount > SLOT_MAX) begin
            w_last_k = SLOT_MAX - rqs_pkg::QCNT_W'(1);
        end else begin
            w_last_k = r_qcount - rqs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_settle  <= 1'b0;
            r_total   <= '0;
            r_dropped <= 1'b0;
            r_k       <= '0;
            r_last_k  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + rqs_pkg::PIX_W'(1);
                end
                ST_IDLE: begin
                    if (w_pix_acc) begin
                        if (w_counted) begin
                            r_total <= r_total + CNT_W'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    r_addr   <= '0;
                    r_settle <= 1'b0;
                    r_last_k <= KW'(w_last_k);
                    r_k      <= '0;
                end
                ST_WALK: begin
                    // A settle step lets the last bin's read data be summed.
                    if (r_addr == '1) begin
                        r_settle <= 1'b1;
                    end
                    if (!r_settle) begin
                        r_addr <= r_addr + rqs_pkg::PIX_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (w_res_acc) begin
                        if (r_k == r_last_k) begin
                            r_total   <= '0;
                            r_dropped <= 1'b0;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Quantile index per slot: floor(count * q / 2^16).
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAIN) begin
            for (int k = 0; k < QUANTILE_SLOTS; k++) begin
                r_idx[k] <= CNT_W'(({{rqs_pkg::Q_W{1'b0}}, r_total} *
                                    {{CNT_W{1'b0}}, r_q[k]}) >> rqs_pkg::Q_W);
            end
        end
    end

    // ---------------- channel units ----------------
    always_comb begin
        w_ctrl.pix_acc    = w_pix_acc;
        w_ctrl.pix_cnt    = w_counted;
        w_ctrl.walk_start = (r_state == ST_DRAIN);
        w_ctrl.walk_rd    = (r_state == ST_WALK) && !r_settle;
        w_ctrl.clear_wr   = (r_state == ST_CLEAR);
        w_ctrl.sweep_addr = r_addr;
    end

    rqs_chan_unit #(.CNT_W(CNT_W), .SLOTS(QUANTILE_SLOTS)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pix   (i_pixel.pixel_red),
        .i_idx   (r_idx),
        .o_sel   (w_sel_r)
    );

    rqs_chan_unit #(.CNT_W(CNT_W), .SLOTS(QUANTILE_SLOTS)) u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pix   (i_pixel.pixel_green),
        .i_idx   (r_idx),
        .o_sel   (w_sel_g)
    );

    rqs_chan_unit #(.CNT_W(CNT_W), .SLOTS(QUANTILE_SLOTS)) u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pix   (i_pixel.pixel_blue),
        .i_idx   (r_idx),
        .o_sel   (w_sel_b)
    );

    // ---------------- results ----------------
    assign o_result.out_red         = w_sel_r[r_k];
    assign o_result.out_green       = w_sel_g[r_k];
    assign o_result.out_blue        = w_sel_b[r_k];
    assign o_result.region_overflow = r_dropped;
    assign o_result.last_result     = (r_k == r_last_k);

    // ---------------- assertions ----------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pixel.ready && o_result.valid))
        else $error("pixel intake open while results are presented");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pix_acc && i_pixel.last_pixel) |=> (r_state == ST_DRAIN))
        else $error("last pixel did not close the region");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_CNT)
        else $error("pixel count above capacity");

    a_region_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_acc && o_result.last_result) |=> ((r_total == '0) && !r_dropped))
        else $error("region state not cleared after final color");

endmodule

// ===== tb/tb_rgb_region_quantile_select.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_region_quantile_select: self-checking bench of the quantile selector
// Streams regions of RGB pixels through the block under bursty input and a
// stalling result sink. A histogram predictor in the bench works out every
// quantile color, and each color request is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_rgb_region_quantile_select;

    localparam int CLK_HALF        = 10;
    localparam int REGION_CAPACITY = 65536;
    localparam int COLOUR_SLOTS    = 4;
    localparam int WALK_LATENCY    = 300;
    localparam int RANDOM_ITEMS    = 480;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_ROWS   = 36;

    localparam logic [rqs_pkg::CFG_IDX_W-1:0] CFG_SPARE = rqs_pkg::CFG_QD + 3'd1;

    typedef struct packed {
        logic [rqs_pkg::PIX_W-1:0] red;
        logic [rqs_pkg::PIX_W-1:0] green;
        logic [rqs_pkg::PIX_W-1:0] blue;
        logic                      last;
    } t_pixel;

    typedef struct packed {
        logic [rqs_pkg::PIX_W-1:0] red;
        logic [rqs_pkg::PIX_W-1:0] green;
        logic [rqs_pkg::PIX_W-1:0] blue;
        logic                      overflow;
        logic                      last;
    } t_colour;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} t_row_kind;
    typedef enum logic [1:0] {TAKE_ALL, TAKE_COIN, TAKE_RARE, TAKE_ALTERNATE} t_take_mode;
    typedef enum logic [1:0] {SPREAD_FULL, SPREAD_PALETTE, SPREAD_NARROW} t_spread;

    typedef struct packed {
        t_row_kind                      kind;
        logic [rqs_pkg::CFG_IDX_W-1:0]  index;
        logic [rqs_pkg::CFG_DATA_W-1:0] data;
        logic [rqs_pkg::PIX_W-1:0]      red;
        logic [rqs_pkg::PIX_W-1:0]      green;
        logic [rqs_pkg::PIX_W-1:0]      blue;
        logic                           last;
        logic                           typed;
        logic [rqs_pkg::PIX_W-1:0]      want_red;
        logic [rqs_pkg::PIX_W-1:0]      want_green;
        logic [rqs_pkg::PIX_W-1:0]      want_blue;
    } t_step_row;

    // Typed colors assume one color per region at that point of the table.
    localparam t_step_row DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1,
          8'hFF, 8'hFF, 8'hFF},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'hAA, 8'h55, 8'h0F, 1'b1, 1'b1,
          8'hAA, 8'h55, 8'h0F},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h0A, 8'hC8, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h14, 8'h64, 8'hFF, 1'b1, 1'b1,
          8'h14, 8'hC8, 8'hFF},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h01, 8'h02, 8'h03, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'hFF, 8'h00, 8'h80, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h07, 8'h07, 8'h07, 1'b1, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QCOUNT, 16'h0004, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QA,     16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QB,     16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QC,     16'h0001, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QD,     16'h8000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h1E, 8'hC8, 8'h05, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h0A, 8'hFA, 8'h09, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h14, 8'h64, 8'h07, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h28, 8'h96, 8'h03, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h32, 8'h00, 8'h01, 1'b1, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QA,     16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h05, 8'h06, 8'h07, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h09, 8'h01, 8'h03, 1'b1, 1'b1,
          8'h09, 8'h06, 8'h07},
        '{ROW_CONFIG, rqs_pkg::CFG_QCOUNT, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QA,     16'h4000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QB,     16'hC000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QC,     16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h00, 8'hFF, 8'h80, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'hFF, 8'h00, 8'h80, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h80, 8'h80, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h40, 8'hC0, 8'hFF, 1'b1, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, CFG_SPARE,  16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, CFG_SPARE + 3'd1, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, CFG_SPARE + 3'd2, 16'h5A5A, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h4D, 8'h58, 8'h63, 1'b1, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_CONFIG, rqs_pkg::CFG_QCOUNT, 16'hFFF9, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
          8'h00, 8'h00, 8'h00},
        '{ROW_PIXEL,  rqs_pkg::CFG_QCOUNT, 16'h0000, 8'h03, 8'h04, 8'h05, 1'b1, 1'b1,
          8'h03, 8'h04, 8'h05}
    };

    logic i_clk;
    logic i_rst_n;

    rqs_cfg_if    cfg_bus ();
    rqs_pixel_if  pixel_bus ();
    rqs_result_if colour_bus ();

    rgb_region_quantile_select #(
        .MAX_PIXELS     (REGION_CAPACITY),
        .QUANTILE_SLOTS (COLOUR_SLOTS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_pixel  (pixel_bus),
        .o_result (colour_bus)
    );

    // Histogram predictor state and its copy of the registers.
    int unsigned                channel_bins [3][rqs_pkg::BINS];
    int unsigned                region_pixels;
    logic                       region_dropped;
    logic [rqs_pkg::QCNT_W-1:0] colour_count_reg;
    logic [rqs_pkg::Q_W-1:0]    fraction_reg [rqs_pkg::Q_REGS];
    t_colour                    pending_colours [$];

    int unsigned burst_left   = 0;
    bit          steady_send  = 1'b0;
    bit          block_idle   = 1'b1;
    bit          hold_off_req = 1'b0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void clear_histograms();
        for (int ch = 0; ch < 3; ch++) begin
            for (int v = 0; v < rqs_pkg::BINS; v++) begin
                channel_bins[ch][v] = 0;
            end
        end
        region_pixels  = 0;
        region_dropped = 1'b0;
    endfunction

    // Smallest value whose running count passes the rank: the sorted element.
    function automatic logic [rqs_pkg::PIX_W-1:0] sorted_at(input int ch,
                                                           input longint unsigned rank);
        longint unsigned running;
        running = 0;
        for (int v = 0; v < rqs_pkg::BINS; v++) begin
            running += channel_bins[ch][v];
            if (running > rank) begin
                return rqs_pkg::PIX_W'(v);
            end
        end
        return '1;
    endfunction

    task automatic tally_pixel(input t_pixel p);
        int              n;
        longint unsigned rank;
        t_colour         c;
        if (region_pixels < REGION_CAPACITY) begin
            channel_bins[0][p.red]++;
            channel_bins[1][p.green]++;
            channel_bins[2][p.blue]++;
            region_pixels++;
        end else begin
            region_dropped = 1'b1;
        end
        if (p.last) begin
            n = int'(colour_count_reg);
            if (n < 1) n = 1;
            if (n > COLOUR_SLOTS) n = COLOUR_SLOTS;
            for (int k = 0; k < n; k++) begin
                rank = (64'(region_pixels) * 64'(fraction_reg[k])) >> 16;
                c.red      = sorted_at(0, rank);
                c.green    = sorted_at(1, rank);
                c.blue     = sorted_at(2, rank);
                c.overflow = region_dropped;
                c.last     = (k == n - 1);
                pending_colours.push_back(c);
            end
            clear_histograms();
        end
    endtask

    function automatic void apply_register(input logic [rqs_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [rqs_pkg::CFG_DATA_W-1:0] value);
        if (idx == rqs_pkg::CFG_QCOUNT) begin
            colour_count_reg = value[rqs_pkg::QCNT_W-1:0];
        end else if (idx >= rqs_pkg::CFG_QA && idx <= rqs_pkg::CFG_QD) begin
            fraction_reg[idx - rqs_pkg::CFG_QA] = value;
        end
    endfunction

    function automatic logic [rqs_pkg::Q_W-1:0] pick_fraction();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return rqs_pkg::Q_RESET;
            3: return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_register(input logic [rqs_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rqs_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        apply_register(idx, value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_pixel(input t_pixel p, input logic typed, input t_colour typed_colour);
        int unsigned gap;
        if (!steady_send && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                pixel_bus.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        pixel_bus.valid       <= 1'b1;
        pixel_bus.pixel_red   <= p.red;
        pixel_bus.pixel_green <= p.green;
        pixel_bus.pixel_blue  <= p.blue;
        pixel_bus.last_pixel  <= p.last;
        @(posedge i_clk);
        while (!pixel_bus.ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        block_idle = 1'b0;
        tally_pixel(p);
        if (typed) begin
            void'(pending_colours.pop_back());
            pending_colours.push_back(typed_colour);
        end
    endtask

    // Lets every color drain and the bin walk finish before registers change.
    task automatic settle_block();
        @(negedge i_clk);
        pixel_bus.valid <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (WALK_LATENCY) @(posedge i_clk);
        burst_left = 0;
        block_idle = 1'b1;
    endtask

    task automatic shuffle_settings();
        write_register(rqs_pkg::CFG_QCOUNT, {13'($urandom), 3'($urandom_range(0, 7))});
        for (int k = 0; k < rqs_pkg::Q_REGS; k++) begin
            write_register(rqs_pkg::CFG_IDX_W'(int'(rqs_pkg::CFG_QA) + k), pick_fraction());
        end
        if ($urandom_range(0, 3) == 0) begin
            write_register(CFG_SPARE + rqs_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                           16'($urandom));
        end
    endtask

    task automatic send_random_region(input int unsigned len);
        t_spread                   spread;
        logic [rqs_pkg::PIX_W-1:0] palette [3][3];
        logic [rqs_pkg::PIX_W-1:0] level [3];
        t_pixel                    p;
        spread = t_spread'($urandom_range(0, 2));
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 3; j++) begin
                palette[ch][j] = rqs_pkg::PIX_W'($urandom);
            end
        end
        for (int unsigned i = 0; i < len; i++) begin
            // Palette and narrow spreads pile counts into few bins, so ties
            // decide the quantile.
            for (int ch = 0; ch < 3; ch++) begin
                case (spread)
                    SPREAD_FULL:    level[ch] = rqs_pkg::PIX_W'($urandom);
                    SPREAD_PALETTE: level[ch] = palette[ch][$urandom_range(0, 2)];
                    default:        level[ch] = palette[ch][0] +
                                                rqs_pkg::PIX_W'($urandom_range(0, 3));
                endcase
            end
            p = '{level[0], level[1], level[2], (i == len - 1)};
            send_pixel(p, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin : colour_check
        t_colour got;
        t_colour want;
        if (i_rst_n && colour_bus.valid && colour_bus.ready) begin
            got.red      = colour_bus.out_red;
            got.green    = colour_bus.out_green;
            got.blue     = colour_bus.out_blue;
            got.overflow = colour_bus.region_overflow;
            got.last     = colour_bus.last_result;
            if (pending_colours.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected color request r=%0d g=%0d b=%0d ovf=%0b last=%0b",
                             got.red, got.green, got.blue, got.overflow, got.last);
                end
            end else begin
                want = pending_colours.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.overflow !== want.overflow ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("color differs: expected r=%0d g=%0d b=%0d ovf=%0b last=%0b",
                                 want.red, want.green, want.blue, want.overflow, want.last);
                        $display("               got      r=%0d g=%0d b=%0d ovf=%0b last=%0b",
                                 got.red, got.green, got.blue, got.overflow, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : colour_sink
        t_take_mode  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = TAKE_ALL;
        mode_left = 0;
        colour_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                colour_bus.ready <= 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                while (hold_left > 1) begin
                    @(negedge i_clk);
                    hold_left--;
                end
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_take_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    TAKE_ALL:  colour_bus.ready <= 1'b1;
                    TAKE_COIN: colour_bus.ready <= 1'($urandom);
                    TAKE_RARE: colour_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:   colour_bus.ready <= ~colour_bus.ready;
                endcase
            end
        end
    end

    initial begin : stimulus
        t_step_row   row;
        t_pixel      p;
        t_colour     typed_colour;
        int unsigned random_items;
        int unsigned regions;
        int unsigned len;
        bit          pressed;

        i_rst_n               = 1'b0;
        pixel_bus.valid       = 1'b0;
        pixel_bus.pixel_red   = '0;
        pixel_bus.pixel_green = '0;
        pixel_bus.pixel_blue  = '0;
        pixel_bus.last_pixel  = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        clear_histograms();
        colour_count_reg = rqs_pkg::QCOUNT_RESET;
        for (int k = 0; k < rqs_pkg::Q_REGS; k++) begin
            fraction_reg[k] = rqs_pkg::Q_RESET;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED_STEPS[i];
            if (row.kind == ROW_CONFIG) begin
                if (!block_idle) settle_block();
                write_register(row.index, row.data);
            end else begin
                p            = '{row.red, row.green, row.blue, row.last};
                typed_colour = '{row.want_red, row.want_green, row.want_blue, 1'b0, 1'b1};
                send_pixel(p, row.typed, typed_colour);
            end
        end

        random_items = 0;
        regions      = 0;
        pressed      = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            if (regions % 6 == 5) begin
                settle_block();
                shuffle_settings();
            end
            // The sink holds off while regions keep coming, so the block backs
            // up and has to refuse pixel requests.
            if (!pressed && random_items >= RANDOM_ITEMS / 2) begin
                hold_off_req = 1'b1;
                steady_send  = 1'b1;
                repeat (12) send_random_region(8);
                steady_send  = 1'b0;
                pressed      = 1'b1;
                random_items += 96;
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            send_random_region(len);
            random_items += len;
            regions++;
        end

        settle_block();
        if (mismatches == 0 && pending_colours.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
